[hw/rtl/mspd_pkg.sv]
// Shared widths, register indexes and helpers for the motor stall/progress detector.
package mspd_pkg;

	localparam int unsigned CUR_W   = 15;
	localparam int unsigned SPD_W   = 15;
	localparam int unsigned TIME_W  = 16;
	localparam int unsigned PROG_W  = 24;
	localparam int unsigned STAMP_W = 32;
	localparam int unsigned POS_W   = 32;
	localparam int unsigned RAW_W   = 16;
	localparam int unsigned MAG_W   = RAW_W + 1;
	localparam int unsigned ADDR_W  = 3;
	localparam int unsigned CDATA_W = 24;
	localparam int unsigned S_DATA_W = 96;
	localparam int unsigned S_USER_W = 2;
	localparam int unsigned M_DATA_W = 8;

	localparam logic [ADDR_W-1:0] REG_UP_CUR_LIMIT   = 3'd0;
	localparam logic [ADDR_W-1:0] REG_DOWN_CUR_LIMIT = 3'd1;
	localparam logic [ADDR_W-1:0] REG_UP_SPD_LIMIT   = 3'd2;
	localparam logic [ADDR_W-1:0] REG_DOWN_SPD_LIMIT = 3'd3;
	localparam logic [ADDR_W-1:0] REG_UP_STALL_TIME  = 3'd4;
	localparam logic [ADDR_W-1:0] REG_DOWN_STALL_TIME = 3'd5;
	localparam logic [ADDR_W-1:0] REG_PROG_MIN       = 3'd6;

	// Magnitude of a 16-bit two's complement reading; -32768 gives 32768.
	function automatic logic [MAG_W-1:0] mag16(input logic [RAW_W-1:0] raw);
		logic [MAG_W-1:0] ext;
		ext = {1'b0, raw};
		if (raw[RAW_W-1]) begin
			return (MAG_W'(1) << RAW_W) - ext;
		end
		return ext;
	endfunction

	// Magnitude of a 32-bit wrapping difference, saturated at 2^31-1.
	function automatic logic [POS_W-2:0] mag32_sat(input logic [POS_W-1:0] v);
		logic [POS_W-1:0] neg;
		neg = '0 - v;
		if (!v[POS_W-1]) begin
			return v[POS_W-2:0];
		end
		if (neg[POS_W-1]) begin
			return {(POS_W-1){1'b1}};
		end
		return neg[POS_W-2:0];
	endfunction

endpackage

[hw/rtl/motor_stall_progress_detector.sv]
// Top level of the motor stall/progress detector: input stage, stall logic and result stage.
//
// Usage. Each transaction on the s_ group carries one motor feedback sample: a
// millisecond timestamp, the phase current, the rotor speed and the encoder
// count in s_tdata, and the clear mode and travel direction in s_tuser. Each
// sample yields exactly one transaction on the m_ group with the stalled flag
// and the end-contact flag. Thresholds and durations are written through the
// cfg_ channel (index 0..6, one register per index, higher indexes ignored);
// cfg_ready is always high and writes are expected only while the block is idle.
//
// Timing. A sample is captured in the input register, evaluated by one level of
// compare/subtract logic and stored in the output register, which drives
// m_tvalid and m_tdata. Throughput is one sample per cycle while m_tready stays
// high: the stall timers and progress window are updated in the same cycle the
// result is registered, so the following sample sees the new state with no gap.
//
// Reset stops the timers and the progress window and clears all configuration
// registers to zero. When the receiver holds m_tready low, the output register
// keeps its result, the input register still takes one more sample if it is
// empty, and s_tready then falls until the output transaction completes.
module motor_stall_progress_detector (
	input  logic                                clk,
	input  logic                                arst_n,
	// Sample stream.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [31:0] time_ms, [47:32] phase_current, [63:48] rotor_speed, [95:64] position_count
	input  logic [mspd_pkg::S_DATA_W-1:0]       s_tdata,
	// [0] mode, [1] going_down
	input  logic [mspd_pkg::S_USER_W-1:0]       s_tuser,
	// Result stream.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [0] stalled, [1] end_contact, [7:2] zero
	output logic [mspd_pkg::M_DATA_W-1:0]       m_tdata,
	// Configuration writes.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mspd_pkg::ADDR_W-1:0]         cfg_addr,
	input  logic [mspd_pkg::CDATA_W-1:0]        cfg_data
);

	// Configuration registers.
	logic [mspd_pkg::CUR_W-1:0]  up_cur_limit_q, down_cur_limit_q;
	logic [mspd_pkg::SPD_W-1:0]  up_spd_limit_q, down_spd_limit_q;
	logic [mspd_pkg::TIME_W-1:0] up_stall_time_q, down_stall_time_q;
	logic [mspd_pkg::PROG_W-1:0] prog_min_q;

	// Input stage.
	logic                          valid_s1;
	logic                          mode_s1;
	logic                          down_s1;
	logic [mspd_pkg::STAMP_W-1:0]  time_s1;
	logic [mspd_pkg::RAW_W-1:0]    current_s1;
	logic [mspd_pkg::RAW_W-1:0]    speed_s1;
	logic [mspd_pkg::POS_W-1:0]    pos_s1;

	// Detector state.
	logic                          win_run_q;
	logic [mspd_pkg::STAMP_W-1:0]  win_time_q;
	logic [mspd_pkg::POS_W-1:0]    win_count_q;
	logic                          win_all_high_q;
	logic                          stall_run_q;
	logic [mspd_pkg::STAMP_W-1:0]  stall_time_q;

	// Output stage.
	logic                          stalled_s2;
	logic                          contact_s2;

	logic                          advance;

	// Evaluation signals.
	logic [mspd_pkg::MAG_W-1:0]    cur_mag, spd_mag;
	logic [mspd_pkg::CUR_W-1:0]    cur_lim;
	logic [mspd_pkg::SPD_W-1:0]    spd_lim;
	logic [mspd_pkg::TIME_W-1:0]   dur;
	logic                          high, low, hold;
	logic [mspd_pkg::STAMP_W-1:0]  win_time_eff, stall_time_eff;
	logic [mspd_pkg::POS_W-1:0]    win_count_eff;
	logic                          all_high_eff;
	logic [mspd_pkg::STAMP_W-1:0]  stall_age, win_age;
	logic [mspd_pkg::POS_W-1:0]    moved;
	logic [mspd_pkg::POS_W-2:0]    moved_mag;
	logic                          cur_stall, win_done, no_prog, stall_hit, contact;

	assign cfg_ready = 1'b1;

	// The output register frees up when empty or when its result is taken; the
	// input register moves on whenever the output register can take its result.
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_cur_limit_q    <= '0;
			down_cur_limit_q  <= '0;
			up_spd_limit_q    <= '0;
			down_spd_limit_q  <= '0;
			up_stall_time_q   <= '0;
			down_stall_time_q <= '0;
			prog_min_q        <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				mspd_pkg::REG_UP_CUR_LIMIT:    up_cur_limit_q    <= cfg_data[mspd_pkg::CUR_W-1:0];
				mspd_pkg::REG_DOWN_CUR_LIMIT:  down_cur_limit_q  <= cfg_data[mspd_pkg::CUR_W-1:0];
				mspd_pkg::REG_UP_SPD_LIMIT:    up_spd_limit_q    <= cfg_data[mspd_pkg::SPD_W-1:0];
				mspd_pkg::REG_DOWN_SPD_LIMIT:  down_spd_limit_q  <= cfg_data[mspd_pkg::SPD_W-1:0];
				mspd_pkg::REG_UP_STALL_TIME:   up_stall_time_q   <= cfg_data[mspd_pkg::TIME_W-1:0];
				mspd_pkg::REG_DOWN_STALL_TIME: down_stall_time_q <= cfg_data[mspd_pkg::TIME_W-1:0];
				mspd_pkg::REG_PROG_MIN:        prog_min_q        <= cfg_data[mspd_pkg::PROG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1    <= s_tuser[0];
			down_s1    <= s_tuser[1];
			time_s1    <= s_tdata[31:0];
			current_s1 <= s_tdata[47:32];
			speed_s1   <= s_tdata[63:48];
			pos_s1     <= s_tdata[95:64];
		end
	end

	always_comb begin
		cur_lim = down_s1 ? down_cur_limit_q : up_cur_limit_q;
		spd_lim = down_s1 ? down_spd_limit_q : up_spd_limit_q;
		dur     = down_s1 ? down_stall_time_q : up_stall_time_q;

		cur_mag = mspd_pkg::mag16(current_s1);
		spd_mag = mspd_pkg::mag16(speed_s1);
		high    = cur_mag >= {2'b00, cur_lim};
		low     = spd_mag <= {2'b00, spd_lim};
		hold    = high && low;

		// A window that is not running opens at this very sample.
		win_time_eff  = win_run_q ? win_time_q : time_s1;
		win_count_eff = win_run_q ? win_count_q : pos_s1;
		all_high_eff  = win_run_q ? (win_all_high_q && high) : high;

		// The current timer starts on the first sample of an unbroken run.
		stall_time_eff = stall_run_q ? stall_time_q : time_s1;

		stall_age = time_s1 - stall_time_eff;
		win_age   = time_s1 - win_time_eff;
		moved     = pos_s1 - win_count_eff;
		moved_mag = mspd_pkg::mag32_sat(moved);

		cur_stall = hold && (stall_age >= {16'd0, dur});
		win_done  = win_age >= {16'd0, dur};
		no_prog   = win_done && (moved_mag < {7'd0, prog_min_q});
		stall_hit = !mode_s1 && (cur_stall || no_prog);
		contact   = stall_hit && (cur_stall || all_high_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_run_q   <= 1'b0;
			stall_run_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			if (mode_s1 || stall_hit) begin
				win_run_q   <= 1'b0;
				stall_run_q <= 1'b0;
			end else begin
				win_run_q   <= 1'b1;
				stall_run_q <= hold;
			end
		end
	end

	// Timer payload; only meaningful while the matching running flag is set.
	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			stall_time_q <= stall_time_eff;
			if (win_done) begin
				win_time_q     <= time_s1;
				win_count_q    <= pos_s1;
				win_all_high_q <= high;
			end else begin
				win_time_q     <= win_time_eff;
				win_count_q    <= win_count_eff;
				win_all_high_q <= all_high_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			stalled_s2 <= stall_hit;
			contact_s2 <= contact;
		end
	end

	assign m_tdata = {6'd0, contact_s2, stalled_s2};

	// A contact report always comes with a stall.
	a_contact_needs_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (stalled_s2 || !contact_s2))
		else $error("end_contact set without stalled");

	// A detected stall stops both timers.
	a_stall_clears_timers: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && stall_hit) |=> (!win_run_q && !stall_run_q))
		else $error("timers still running after a stall");

	// Clear mode stops both timers and reports nothing.
	a_clear_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && mode_s1) |=> (!win_run_q && !stall_run_q && !stalled_s2))
		else $error("clear mode left a timer running or reported a stall");

	// An evaluated sample outside clear mode and without a stall leaves the progress window running.
	a_window_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && !mode_s1 && !stall_hit) |=> win_run_q)
		else $error("progress window not running after a normal sample");

endmodule
